>>> sv/stu_pkg.sv
package stu_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int RECIP_BITS    = 24;
   localparam int RECIP_W       = 22;
   localparam int ARG_W         = 21;
   localparam int SUM_W         = 32;
   localparam int IDX_W         = 6;
   localparam int SQ_W          = 25;
   localparam int MAG_W         = 37;
   localparam int MAX_TERMS_DEF = 64;

   // one item in flight between term stages
   typedef struct packed {
      logic                    neg;
      logic [IDX_W-1:0]        last;
      logic [SQ_W-1:0]         sq;
      logic [MAG_W-1:0]        mag;
      logic signed [SUM_W-1:0] sum;
   } stu_item_type;

endpackage

>>> sv/stu_if.sv
interface stu_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [stu_pkg::ARG_W-1:0]       argument;

   modport source (output valid, output argument, input ready);
   modport sink (input valid, input argument, output ready);
endinterface

interface stu_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [stu_pkg::SUM_W-1:0]       series_value;

   modport source (output valid, output series_value, input ready);
   modport sink (input valid, input series_value, output ready);
endinterface

>>> sv/sine_taylor_series_unit.sv
// sine_taylor_series_unit: truncated maclaurin series of sin(x) in q16.16
// req_bus (sink): one beat carries argument, a signed q5.16 x
// rsp_bus (source): one beat carries series_value, the saturated partial sum
// csr_write_enable / csr_write_data: highest_term_index, index of the last term
//   summed (0 gives only the x term), clamped to MAX_TERMS-1; write only while idle
// each term has its own four stages: reciprocal multiply, round, x-squared
//   multiply, round and saturating add; a front end of two stages takes |x| and x^2
// every beat runs through the front end and all MAX_TERMS term groups, whatever the term count
// throughput: one beat per cycle while rsp_bus is not held, set by the fully pipelined term chain
// reset: synchronous, clears all valid bits and sets highest_term_index to 0
// stall: when rsp_bus is held, the whole chain freezes and req_bus.ready drops;
//   nothing in flight is lost or repeated
module sine_taylor_series_unit #(
   parameter int MAX_TERMS = stu_pkg::MAX_TERMS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   stu_req_if.sink                       req_bus,
   stu_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [stu_pkg::IDX_W-1:0]     csr_write_data
);
   import stu_pkg::*;

   logic [IDX_W-1:0] last_ff, last_in;
   logic             advance;
   logic             chain_valid [MAX_TERMS+1];
   stu_item_type     chain_item  [MAX_TERMS+1];

   // config register
   always_comb begin
      last_in = csr_write_enable ? csr_write_data : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

   // single pipeline enable: move when the output slot is empty or taken
   assign advance       = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   stu_front #(.MAX_TERMS(MAX_TERMS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_bus.valid),
      .in_argument (req_bus.argument),
      .in_last     (last_ff),
      .out_valid   (chain_valid[0]),
      .out_item    (chain_item[0])
   );

   // one stage group per series term after the first
   for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
      stu_term #(.K(k)) u_term (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[k]),
         .in_item   (chain_item[k]),
         .out_valid (chain_valid[k+1]),
         .out_item  (chain_item[k+1])
      );
   end

   assign rsp_bus.valid        = chain_valid[MAX_TERMS];
   assign rsp_bus.series_value = chain_item[MAX_TERMS].sum;

`ifndef ASSERT_OFF
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input taken while output stalled");
   a_csr_load: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> last_ff == $past(csr_write_data))
      else $error("term index not loaded");
   a_reset_idx: assert property (@(posedge clock)
      reset |=> last_ff == '0)
      else $error("term index not cleared by reset");
`endif

endmodule

>>> sv/stu_front.sv
module stu_front #(
   parameter int MAX_TERMS = stu_pkg::MAX_TERMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic signed [stu_pkg::ARG_W-1:0]   in_argument,
   input  logic [stu_pkg::IDX_W-1:0]          in_last,
   output logic                               out_valid,
   output stu_pkg::stu_item_type              out_item
);
   import stu_pkg::*;

   localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(MAX_TERMS - 1);

   logic                 a_valid_ff, a_valid_in;
   logic                 a_neg_ff, a_neg_in;
   logic [ARG_W-1:0]     a_mag_ff, a_mag_in;
   logic [IDX_W-1:0]     a_last_ff, a_last_in;
   logic [2*ARG_W-1:0]   square;
   stu_item_type         b_item_in;

   // stage a: magnitude and sign, clamp of the term count
   always_comb begin
      a_valid_in = in_valid;
      a_neg_in   = in_argument[ARG_W-1];
      a_mag_in   = a_neg_in ? ARG_W'(-in_argument) : ARG_W'(in_argument);
      a_last_in  = (in_last > LAST_MAX) ? LAST_MAX : in_last;
   end

   // stage b: rounded square, first term
   always_comb begin
      square         = 42'(a_mag_ff) * 42'(a_mag_ff);
      b_item_in.neg  = a_neg_ff;
      b_item_in.last = a_last_ff;
      b_item_in.sq   = SQ_W'((square + (42'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      b_item_in.mag  = MAG_W'(a_mag_ff);
      b_item_in.sum  = a_neg_ff ? -SUM_W'(a_mag_ff) : SUM_W'(a_mag_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         out_valid  <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         out_valid  <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_neg_ff  <= a_neg_in;
         a_mag_ff  <= a_mag_in;
         a_last_ff <= a_last_in;
         out_item  <= b_item_in;
      end
   end

endmodule

>>> sv/stu_term.sv
module stu_term #(
   parameter int K = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  stu_pkg::stu_item_type in_item,
   output logic                  out_valid,
   output stu_pkg::stu_item_type out_item
);
   import stu_pkg::*;

   localparam int unsigned DENOM = (2 * K + 2) * (2 * K + 3);
   localparam int unsigned RECIP_VAL = ((1 << RECIP_BITS) + DENOM / 2) / DENOM;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam logic ODD_TERM = ((K + 1) % 2) == 1;

   logic          a_valid_ff, b_valid_ff, c_valid_ff;
   stu_item_type  a_item_ff, b_item_ff, c_item_ff;
   logic [39:0]   a_lo_ff, a_lo_in;
   logic [40:0]   a_hi_ff, a_hi_in;
   logic [35:0]   b_m_ff, b_m_in;
   logic [42:0]   c_lo_ff, c_lo_in, c_hi_ff, c_hi_in;
   logic [58:0]   p_sum;
   logic [60:0]   q_sum;
   logic [MAG_W-1:0] next_mag;
   logic          active, term_neg;
   logic signed [39:0] s_wide;
   stu_item_type  d_item_in;

   // stage a: magnitude times reciprocal, two partial products
   always_comb begin
      a_lo_in = 40'(in_item.mag[17:0]) * 40'(RECIP);
      a_hi_in = 41'(in_item.mag[MAG_W-1:18]) * 41'(RECIP);
   end

   // stage b: combine and round
   always_comb begin
      p_sum  = (59'(a_hi_ff) << 18) + 59'(a_lo_ff) + (59'(1) << (RECIP_BITS - 1));
      b_m_in = 36'(p_sum >> RECIP_BITS);
   end

   // stage c: times x squared, two partial products
   always_comb begin
      c_lo_in = 43'(b_m_ff[17:0]) * 43'(b_item_ff.sq);
      c_hi_in = 43'(b_m_ff[35:18]) * 43'(b_item_ff.sq);
   end

   // stage d: round, signed add with clamp, pass through when past the last term
   always_comb begin
      q_sum    = (61'(c_hi_ff) << 18) + 61'(c_lo_ff) + (61'(1) << (FRAC_BITS - 1));
      next_mag = MAG_W'(q_sum >> FRAC_BITS);
      active   = c_item_ff.last > IDX_W'(K);
      term_neg = c_item_ff.neg ^ ODD_TERM;
      s_wide   = term_neg ? 40'(c_item_ff.sum) - $signed({3'b000, next_mag})
                          : 40'(c_item_ff.sum) + $signed({3'b000, next_mag});
      d_item_in = c_item_ff;
      if (active) begin
         d_item_in.mag = next_mag;
         if (s_wide > 40'sd2147483647) begin
            d_item_in.sum = 32'sh7fffffff;
         end else if (s_wide < -40'sd2147483648) begin
            d_item_in.sum = 32'sh80000000;
         end else begin
            d_item_in.sum = SUM_W'(s_wide);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         out_valid  <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         out_valid  <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_item_ff <= in_item;
         a_lo_ff   <= a_lo_in;
         a_hi_ff   <= a_hi_in;
         b_item_ff <= a_item_ff;
         b_m_ff    <= b_m_in;
         c_item_ff <= b_item_ff;
         c_lo_ff   <= c_lo_in;
         c_hi_ff   <= c_hi_in;
         out_item  <= d_item_in;
      end
   end

`ifndef ASSERT_OFF
   a_idle_pass: assert property (@(posedge clock) disable iff (reset)
      advance && c_valid_ff && !active |=> out_item.sum == $past(c_item_ff.sum))
      else $error("sum changed past the last term");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_item) && $stable(out_valid))
      else $error("term output moved during stall");
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !a_valid_ff && !out_valid)
      else $error("valid survived reset");
`endif

endmodule
